>>> sv/tpsl_pkg.sv
// ----------------------------------------------------------------------------
// tpsl_pkg
// Shared constants, status codes and types of the TTML PES segment locator.
// ----------------------------------------------------------------------------
package tpsl_pkg;

  // Field and value widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SCALE_W  = 12;
  localparam int unsigned RAW_W    = 48;
  localparam int unsigned TICKS_W  = RAW_W + SCALE_W;

  // Field layout
  localparam logic [LEN_W-1:0] MAX_FIELD_BYTES = 16'd65535;
  localparam logic [LEN_W-1:0] HDR_BYTES       = 16'd7;
  localparam logic [LEN_W-1:0] CRC_BYTES       = 16'd4;
  localparam logic [LEN_W-1:0] MIN_FIELD_BYTES = HDR_BYTES + CRC_BYTES;
  localparam logic [LEN_W:0]   SEG_HDR_BYTES   = 17'd3;
  localparam logic [LEN_W-1:0] TIME_BYTES      = 16'd6;

  // Segment types
  localparam logic [BYTE_W-1:0] KIND_PLAIN = 8'h01;
  localparam logic [BYTE_W-1:0] KIND_GZIP  = 8'h02;

  localparam logic [SCALE_W-1:0] TIME_SCALE_RESET = 12'd2700;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PLAIN     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GZIP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOSEG     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNC_HDR = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TRUNC_SEG = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd6;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  field_length;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    doc_offset;
    logic [LEN_W-1:0]    doc_length;
    logic [RAW_W-1:0]    media_time;
    logic                time_zero;
  } result_t;

endpackage

>>> sv/tpsl_if.sv
// ----------------------------------------------------------------------------
// tpsl_if
// Valid/ready channels of the segment locator: data bytes, results, config.
// ----------------------------------------------------------------------------
interface tpsl_in_if
  import tpsl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0]  field_length;

  modport source (output valid, data_byte, field_length, input ready);
  modport sink   (input valid, data_byte, field_length, output ready);
endinterface

interface tpsl_out_if
  import tpsl_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [LEN_W-1:0]    doc_offset;
  logic [LEN_W-1:0]    doc_length;
  logic [RAW_W-1:0]    media_time_raw;
  logic [TICKS_W-1:0]  media_time_ticks;

  modport source (output valid, status, doc_offset, doc_length, media_time_raw,
                  media_time_ticks, input ready);
  modport sink   (input valid, status, doc_offset, doc_length, media_time_raw,
                  media_time_ticks, output ready);
endinterface

interface tpsl_cfg_if
  import tpsl_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SCALE_W-1:0] time_scale;

  modport source (output valid, time_scale, input ready);
  modport sink   (input valid, time_scale, output ready);
endinterface

>>> sv/tpsl_in_reg.sv
// ----------------------------------------------------------------------------
// tpsl_in_reg
// Input register: holds one data byte request until the parser consumes it.
// ----------------------------------------------------------------------------
module tpsl_in_reg
  import tpsl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  tpsl_in_if.sink   in_if,
  input  logic      advance_i,
  output logic      valid_o,
  output in_item_t  item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     accept;

  assign in_if.ready = !valid_q || advance_i;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data_byte    <= in_if.data_byte;
      item_q.field_length <= in_if.field_length;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> sv/tpsl_parser.sv
// ----------------------------------------------------------------------------
// tpsl_parser
// Per-byte parse state: media time, segment count and segment header walk.
// ----------------------------------------------------------------------------
module tpsl_parser
  import tpsl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  in_item_t item_i,
  input  logic     fire_i,
  output logic     last_o,
  output result_t  res_o
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_TYPE   = 3'd1;
  localparam logic [2:0] PH_LEN_HI = 3'd2;
  localparam logic [2:0] PH_LEN_LO = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  logic [LEN_W-1:0]    pos_q, pos_d;
  logic [LEN_W-1:0]    fsize_q, fsize_d;
  logic [RAW_W-1:0]    acc_q, acc_d;
  logic [BYTE_W-1:0]   segs_q, segs_d;
  logic [2:0]          phase_q, phase_d;
  logic [BYTE_W-1:0]   kind_q, kind_d;
  logic [BYTE_W-1:0]   seg_hi_q, seg_hi_d;
  logic [LEN_W-1:0]    nhp_q, nhp_d;
  logic [STATUS_W-1:0] code_q, code_d;
  logic [LEN_W-1:0]    foff_q, foff_d;
  logic [LEN_W-1:0]    flen_q, flen_d;

  logic [BYTE_W-1:0] b;
  logic [LEN_W-1:0]  len_sat;
  logic [LEN_W-1:0]  fend;
  logic [LEN_W:0]    start;
  logic [LEN_W-1:0]  seg_size;
  logic [LEN_W:0]    seg_end;
  logic [BYTE_W-1:0] segs_next;
  logic              last;
  logic              found;

  always_comb begin
    b = item_i.data_byte;

    // Saturate the sampled length into 1 .. MAX_FIELD_BYTES
    if (item_i.field_length == '0) begin
      len_sat = 16'd1;
    end else if (item_i.field_length > MAX_FIELD_BYTES) begin
      len_sat = MAX_FIELD_BYTES;
    end else begin
      len_sat = item_i.field_length;
    end

    pos_d    = pos_q;
    fsize_d  = (pos_q == '0) ? len_sat : fsize_q;
    acc_d    = acc_q;
    segs_d   = segs_q;
    phase_d  = phase_q;
    kind_d   = kind_q;
    seg_hi_d = seg_hi_q;
    nhp_d    = nhp_q;
    code_d   = code_q;
    foff_d   = foff_q;
    flen_d   = flen_q;

    start     = {1'b0, pos_q} + 17'd1;
    seg_size  = {seg_hi_q, b};
    seg_end   = start + {1'b0, seg_size};
    segs_next = segs_q - 8'd1;

    if ((pos_q == '0) && (fsize_d < MIN_FIELD_BYTES)) begin
      code_d  = ST_SHORT;
      phase_d = PH_DONE;
    end

    fend = fsize_d - CRC_BYTES;

    case (phase_d)
      PH_HEADER: begin
        if (pos_q < TIME_BYTES) begin
          acc_d = {acc_q[RAW_W-BYTE_W-1:0], b};
        end else if (pos_q == TIME_BYTES) begin
          segs_d = b;
          if (b == '0) begin
            code_d  = ST_NOSEG;
            phase_d = PH_DONE;
          end else begin
            nhp_d = HDR_BYTES;
            if (({1'b0, HDR_BYTES} + SEG_HDR_BYTES) > {1'b0, fend}) begin
              code_d  = ST_TRUNC_HDR;
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_TYPE;
            end
          end
        end
      end
      PH_TYPE: begin
        if (pos_q == nhp_q) begin
          kind_d  = b;
          phase_d = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        seg_hi_d = b;
        phase_d  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (seg_end > {1'b0, fend}) begin
          code_d  = ST_TRUNC_SEG;
          phase_d = PH_DONE;
        end else if ((kind_q == KIND_PLAIN) || (kind_q == KIND_GZIP)) begin
          foff_d  = start[LEN_W-1:0];
          flen_d  = seg_size;
          code_d  = (kind_q == KIND_GZIP) ? ST_GZIP : ST_PLAIN;
          phase_d = PH_DONE;
        end else begin
          // Skip this segment, then check room for the next header
          segs_d = segs_next;
          nhp_d  = seg_end[LEN_W-1:0];
          if (segs_next == '0) begin
            code_d  = ST_NONE;
            phase_d = PH_DONE;
          end else if ((seg_end + SEG_HDR_BYTES) > {1'b0, fend}) begin
            code_d  = ST_TRUNC_HDR;
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_TYPE;
          end
        end
      end
      default: begin
      end
    endcase

    last  = start >= {1'b0, fsize_d};
    found = (code_d == ST_PLAIN) || (code_d == ST_GZIP);

    res_o.status     = code_d;
    res_o.doc_offset = found ? foff_d : '0;
    res_o.doc_length = found ? flen_d : '0;
    // A field long enough to parse ends past the time bytes, so acc_q is final
    res_o.media_time = acc_q;
    res_o.time_zero  = (code_d == ST_SHORT);

    if (last) begin
      pos_d    = '0;
      fsize_d  = '0;
      acc_d    = '0;
      segs_d   = '0;
      phase_d  = PH_HEADER;
      kind_d   = '0;
      seg_hi_d = '0;
      nhp_d    = HDR_BYTES;
      code_d   = ST_NONE;
      foff_d   = '0;
      flen_d   = '0;
    end else begin
      pos_d = start[LEN_W-1:0];
    end
  end

  assign last_o = valid_i && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      fsize_q  <= '0;
      acc_q    <= '0;
      segs_q   <= '0;
      phase_q  <= PH_HEADER;
      kind_q   <= '0;
      seg_hi_q <= '0;
      nhp_q    <= HDR_BYTES;
      code_q   <= ST_NONE;
      foff_q   <= '0;
      flen_q   <= '0;
    end else if (fire_i) begin
      pos_q    <= pos_d;
      fsize_q  <= fsize_d;
      acc_q    <= acc_d;
      segs_q   <= segs_d;
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      seg_hi_q <= seg_hi_d;
      nhp_q    <= nhp_d;
      code_q   <= code_d;
      foff_q   <= foff_d;
      flen_q   <= flen_d;
    end
  end

endmodule

>>> sv/tpsl_out_reg.sv
// ----------------------------------------------------------------------------
// tpsl_out_reg
// Result register: scale the media time to ticks and hold the result request.
// ----------------------------------------------------------------------------
module tpsl_out_reg
  import tpsl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  result_t            res_i,
  input  logic [SCALE_W-1:0] time_scale_i,
  output logic               space_o,
  tpsl_out_if.source         out_if
);

  logic                valid_q, valid_d;
  logic [STATUS_W-1:0] status_q;
  logic [LEN_W-1:0]    offset_q;
  logic [LEN_W-1:0]    length_q;
  logic [RAW_W-1:0]    raw_q;
  logic [TICKS_W-1:0]  ticks_q;
  logic [TICKS_W-1:0]  product;

  // 48 x 12 multiply straight from the parse state register
  assign product = {{SCALE_W{1'b0}}, res_i.media_time} *
                   {{RAW_W{1'b0}}, time_scale_i};

  assign space_o = !valid_q || out_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_if.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q <= res_i.status;
      offset_q <= res_i.doc_offset;
      length_q <= res_i.doc_length;
      raw_q    <= res_i.time_zero ? '0 : res_i.media_time;
      ticks_q  <= res_i.time_zero ? '0 : product;
    end
  end

  assign out_if.valid            = valid_q;
  assign out_if.status           = status_q;
  assign out_if.doc_offset       = offset_q;
  assign out_if.doc_length       = length_q;
  assign out_if.media_time_raw   = raw_q;
  assign out_if.media_time_ticks = ticks_q;

endmodule

>>> sv/ttml_pes_segment_locator_core.sv
// ----------------------------------------------------------------------------
// ttml_pes_segment_locator_core
// Locates the first TTML segment of a DVB TTML PES data field, byte by byte.
// ----------------------------------------------------------------------------
// The block takes one data field byte per cycle, sustained, with no gaps
// needed between fields. Each byte request is held in an input register and
// parsed from there by a single compare-and-capture step; on the last byte
// of a field the result request lands in the output register at the edge
// that consumes that byte, so a result is offered in the cycle after its
// last byte was consumed. The media time to tick conversion is a 48 x 12
// multiply that sits alone between the parse state and the output register.
// The output register decouples the two sides: bytes keep flowing while a
// result waits, and only a last byte stalls when an earlier result has not
// yet been taken. The field length travels with every byte but is sampled on
// the first byte of a field only. time_scale resets to 2700 and should be
// written only while no field is in flight; the write channel is always
// ready. There is no clearing pass after reset.
module ttml_pes_segment_locator_core
  import tpsl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tpsl_in_if.sink     in_if,
  tpsl_out_if.source  out_if,
  tpsl_cfg_if.sink    cfg_if
);

  logic               in_valid;
  in_item_t           in_item;
  logic               advance;
  logic               last;
  logic               space;
  result_t            res;
  logic [SCALE_W-1:0] time_scale_q;

  // Config write: always take it
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_scale_q <= TIME_SCALE_RESET;
    end else if (cfg_if.valid) begin
      time_scale_q <= cfg_if.time_scale;
    end
  end

  // Advance the held byte unless it ends a field and the result slot is full
  assign advance = in_valid && (!last || space);

  tpsl_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_if),
    .advance_i (advance),
    .valid_o   (in_valid),
    .item_o    (in_item)
  );

  tpsl_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .item_i  (in_item),
    .fire_i  (advance),
    .last_o  (last),
    .res_o   (res)
  );

  tpsl_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance && last),
    .res_i        (res),
    .time_scale_i (time_scale_q),
    .space_o      (space),
    .out_if       (out_if)
  );

  // A finished field always shows up as a result request next cycle
  a_result_follows_last : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && last) |=> out_if.valid
  ) else $error("last byte consumed without a result request");

  // Never drop a pending result by loading over it
  a_no_overwrite : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |-> !(advance && last)
  ) else $error("result overwritten while still pending");

  a_status_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.status <= ST_NONE)
  ) else $error("status code out of range");

  a_no_doc_unless_found : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && (out_if.status != ST_PLAIN) && (out_if.status != ST_GZIP))
      |-> ((out_if.doc_offset == '0) && (out_if.doc_length == '0))
  ) else $error("document location reported without a TTML segment");

  a_short_zero_time : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && (out_if.status == ST_SHORT))
      |-> ((out_if.media_time_raw == '0) && (out_if.media_time_ticks == '0))
  ) else $error("media time reported for a too short field");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TTML PES segment locator core.
// ----------------------------------------------------------------------------
// Streams PES data fields into the block one byte request at a time. A
// byte-level predictor tracks the parse of each field and queues the result
// expected on its last byte. Each result request taken from the block is
// compared with the oldest queued result, field by field. The stimulus starts
// with directed fields for every status and boundary, then sweeps
// time_scale settings, then runs mostly well-formed random fields mixed
// with broken and noise fields. Random gaps on the byte side and random
// stalls on the result side run throughout, except in the closing part.
// ----------------------------------------------------------------------------
module tb;
  import tpsl_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned RANDOM_BYTES  = 100;
  localparam int unsigned RANDOM_FIELDS = 4;
  localparam int unsigned SHOW_LIMIT    = 40;

  typedef bit [7:0] byte_q_t[$];

  // Parse phases of the predictor
  typedef enum logic [2:0] {
    LOC_TIME,
    LOC_TYPE,
    LOC_LEN_HI,
    LOC_LEN_LO,
    LOC_DONE
  } loc_phase_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    doc_offset;
    logic [LEN_W-1:0]    doc_length;
    logic [RAW_W-1:0]    raw;
    logic [TICKS_W-1:0]  ticks;
  } loc_result_t;

  logic clk_i;
  logic rst_ni;

  tpsl_in_if  byte_bus ();
  tpsl_out_if result_bus ();
  tpsl_cfg_if cfg_bus ();

  ttml_pes_segment_locator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (byte_bus),
    .out_if (result_bus),
    .cfg_if (cfg_bus)
  );

  // Predictor state: one copy of the parse registers and the time scale
  logic [SCALE_W-1:0]  loc_scale;
  logic [LEN_W-1:0]    loc_pos;
  logic [LEN_W-1:0]    loc_size;
  logic [RAW_W-1:0]    loc_mtime;
  logic [7:0]          loc_segs_left;
  loc_phase_e          loc_phase;
  logic [7:0]          loc_kind;
  logic [LEN_W-1:0]    loc_seg_size;
  logic [LEN_W-1:0]    loc_next_hdr;
  logic [STATUS_W-1:0] loc_outcome;
  logic [LEN_W-1:0]    loc_found_off;
  logic [LEN_W-1:0]    loc_found_len;

  // Results predicted but not yet taken from the block, oldest first
  loc_result_t pending_results[$];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned bytes_sent   = 0;
  int unsigned fields_sent  = 0;
  int unsigned scale_writes = 0;
  int unsigned cycle_count  = 0;
  int unsigned status_tally[8];
  int unsigned src_gap_odds = 0;
  bit          quiet_tail   = 1'b0;

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stop a hung run: the slowest correct run stays far below this count.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function void clear_field();
    loc_pos       = '0;
    loc_size      = '0;
    loc_mtime     = '0;
    loc_segs_left = '0;
    loc_phase     = LOC_TIME;
    loc_kind      = '0;
    loc_seg_size  = '0;
    loc_next_hdr  = HDR_BYTES;
    loc_outcome   = ST_NONE;
    loc_found_off = '0;
    loc_found_len = '0;
  endfunction

  function void close_field(input logic [STATUS_W-1:0] code);
    loc_outcome = code;
    loc_phase   = LOC_DONE;
  endfunction

  // At a segment header position: stop when the count is used up or the
  // header would run into the CRC, else wait for the type byte.
  function void check_next_header();
    int unsigned field_end;
    field_end = loc_size - CRC_BYTES;
    if (loc_segs_left == 0) begin
      close_field(ST_NONE);
    end else if (loc_next_hdr + SEG_HDR_BYTES > field_end) begin
      close_field(ST_TRUNC_HDR);
    end else begin
      loc_phase = LOC_TYPE;
    end
  endfunction

  // Advance the parse by one accepted byte; return 1 with the result on the
  // last byte of a field.
  function automatic bit advance_locator(input logic [7:0] data_b,
                                         input logic [LEN_W-1:0] flen,
                                         output loc_result_t res);
    int unsigned p;
    int unsigned len;
    int unsigned start;
    int unsigned field_end;
    p   = loc_pos;
    res = '0;
    // Sample the field length on the first byte only
    if (p == 0) begin
      len = flen;
      if (len == 0) len = 1;
      if (len > MAX_FIELD_BYTES) len = MAX_FIELD_BYTES;
      loc_size = LEN_W'(len);
      if (len < MIN_FIELD_BYTES) close_field(ST_SHORT);
    end
    case (loc_phase)
      LOC_TIME: begin
        if (p < TIME_BYTES) begin
          loc_mtime = {loc_mtime[RAW_W-9:0], data_b};
        end else if (p == TIME_BYTES) begin
          loc_segs_left = data_b;
          if (data_b == 0) begin
            close_field(ST_NOSEG);
          end else begin
            loc_next_hdr = HDR_BYTES;
            check_next_header();
          end
        end
      end
      LOC_TYPE: begin
        if (p == loc_next_hdr) begin
          loc_kind  = data_b;
          loc_phase = LOC_LEN_HI;
        end
      end
      LOC_LEN_HI: begin
        loc_seg_size = {data_b, 8'h00};
        loc_phase    = LOC_LEN_LO;
      end
      LOC_LEN_LO: begin
        start             = p + 1;
        field_end         = loc_size - CRC_BYTES;
        loc_seg_size[7:0] = data_b;
        if (start + loc_seg_size > field_end) begin
          close_field(ST_TRUNC_SEG);
        end else if (loc_kind == KIND_PLAIN || loc_kind == KIND_GZIP) begin
          loc_found_off = LEN_W'(start);
          loc_found_len = loc_seg_size;
          close_field(loc_kind == KIND_GZIP ? ST_GZIP : ST_PLAIN);
        end else begin
          loc_segs_left = loc_segs_left - 8'd1;
          loc_next_hdr  = LEN_W'(start + loc_seg_size);
          check_next_header();
        end
      end
      default: ;
    endcase
    if (p + 1 >= loc_size) begin
      res.status = loc_outcome;
      if (loc_outcome == ST_PLAIN || loc_outcome == ST_GZIP) begin
        res.doc_offset = loc_found_off;
        res.doc_length = loc_found_len;
      end
      res.raw   = (loc_outcome == ST_SHORT) ? '0 : loc_mtime;
      res.ticks = TICKS_W'(res.raw) * TICKS_W'(loc_scale);
      clear_field();
      return 1'b1;
    end
    loc_pos = LEN_W'(p + 1);
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Field building helpers
  // --------------------------------------------------------------------------
  function automatic void add_random(ref byte_q_t q, input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_seg_header(ref byte_q_t q, input logic [7:0] kind,
                                         input logic [LEN_W-1:0] seg_len);
    q.push_back(kind);
    q.push_back(seg_len[15:8]);
    q.push_back(seg_len[7:0]);
  endfunction

  function automatic void add_segment(ref byte_q_t q, input logic [7:0] kind,
                                      input int unsigned seg_len);
    add_seg_header(q, kind, LEN_W'(seg_len));
    add_random(q, seg_len);
  endfunction

  // Media time, big endian, then the segment count
  function automatic byte_q_t field_head(input logic [RAW_W-1:0] mtime,
                                         input logic [7:0] count);
    byte_q_t q;
    int i;
    q = {};
    for (i = 5; i >= 0; i--) q.push_back(mtime[8*i +: 8]);
    q.push_back(count);
    return q;
  endfunction

  // Well-formed field: a few skipped segments, usually a TTML segment, some
  // padding and the CRC. The count byte mostly covers every segment.
  function automatic byte_q_t build_random_field();
    byte_q_t q;
    int unsigned skips;
    int unsigned i;
    int unsigned nseg;
    logic [7:0] kind;
    bit has_doc;
    q     = field_head(RAW_W'({$urandom, $urandom}), 8'd0);
    skips = $urandom_range(0, 3);
    for (i = 0; i < skips; i++) begin
      kind = 8'($urandom_range(0, 255));
      if (kind == KIND_PLAIN || kind == KIND_GZIP) kind = kind ^ 8'h80;
      add_segment(q, kind, $urandom_range(0, 8));
    end
    has_doc = ($urandom_range(0, 9) != 0);
    if (has_doc) begin
      add_segment(q, $urandom_range(0, 1) ? KIND_GZIP : KIND_PLAIN, $urandom_range(0, 12));
    end
    nseg = skips + has_doc;
    case ($urandom_range(0, 9))
      0, 1:    q[6] = 8'($urandom_range(0, nseg));
      2:       q[6] = 8'hFF;
      default: q[6] = 8'(nseg + $urandom_range(0, 2));
    endcase
    add_random(q, $urandom_range(0, 2) + CRC_BYTES);
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Send one byte request; predict once the block has taken it.
  task automatic send_byte(input logic [7:0] data_b, input logic [LEN_W-1:0] flen);
    int unsigned gap;
    loc_result_t res;
    if (!quiet_tail && src_gap_odds != 0 && $urandom_range(1, src_gap_odds) == 1) begin
      gap = $urandom_range(1, 16);
      byte_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_bus.valid        <= 1'b1;
    byte_bus.data_byte    <= data_b;
    byte_bus.field_length <= flen;
    do @(posedge clk_i); while (byte_bus.ready !== 1'b1);
    if (advance_locator(data_b, flen, res)) pending_results.push_back(res);
    bytes_sent++;
  endtask

  // Send a whole field: as many bytes as the length says, padding with
  // random bytes past the built content and dropping what lies beyond.
  task automatic send_field(input byte_q_t bytes, input logic [LEN_W-1:0] flen);
    int unsigned n;
    int unsigned i;
    n = (flen == 0) ? 1 : flen;
    case ($urandom_range(0, 2))
      0:       src_gap_odds = 0;
      1:       src_gap_odds = 3;
      default: src_gap_odds = 12;
    endcase
    for (i = 0; i < n; i++) begin
      send_byte((i < bytes.size()) ? bytes[i] : 8'($urandom_range(0, 255)),
                (i == 0) ? flen : LEN_W'($urandom_range(0, 65535)));
    end
    fields_sent++;
  endtask

  // Hold the byte side, wait for every result and the pipe to empty, then
  // write the register.
  task automatic program_time_scale(input logic [SCALE_W-1:0] value);
    byte_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.time_scale <= value;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    loc_scale = value;
    scale_writes++;
  endtask

  // Result side: stall in bursts of random length; the stall rate is redrawn
  // at random intervals and is sometimes zero.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned odds;
    int unsigned span;
    stall_left = 0;
    odds       = 0;
    span       = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (span == 0) begin
        span = $urandom_range(50, 300);
        case ($urandom_range(0, 2))
          0:       odds = 0;
          1:       odds = 3;
          default: odds = 12;
        endcase
      end
      span--;
      if (quiet_tail) begin
        result_bus.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else if (odds != 0 && $urandom_range(1, odds) == 1) begin
        stall_left = $urandom_range(1, 16) - 1;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= SHOW_LIMIT) begin
      $display("%0t: %s mismatch at result %0d: got 0x%0h, expected 0x%0h",
               $time, what, results_seen, got, want);
    end
  endtask

  // Compare every taken result request with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    loc_result_t want;
    if (rst_ni === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", result_bus.status, '0);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        status_tally[want.status]++;
        if (result_bus.status !== want.status)
          report_mismatch("status", result_bus.status, want.status);
        if (result_bus.doc_offset !== want.doc_offset)
          report_mismatch("doc_offset", result_bus.doc_offset, want.doc_offset);
        if (result_bus.doc_length !== want.doc_length)
          report_mismatch("doc_length", result_bus.doc_length, want.doc_length);
        if (result_bus.media_time_raw !== want.raw)
          report_mismatch("media_time_raw", result_bus.media_time_raw, want.raw);
        if (result_bus.media_time_ticks !== want.ticks)
          report_mismatch("media_time_ticks", result_bus.media_time_ticks, want.ticks);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Fields below the minimum size, including a zero length taken as one byte
  task automatic test_short_fields();
    byte_q_t q;
    q = {};
    send_field(q, '0);
    add_random(q, 10);
    send_field(q, 16'd10);
    send_field(q, 16'd1);
    q = field_head('1, 8'd1);
    send_field(q, MIN_FIELD_BYTES - 1);
  endtask

  // Walk the segment headers through every stop condition
  task automatic test_segment_walk();
    byte_q_t q;
    // Zero segment count
    q = field_head(RAW_W'({$urandom, $urandom}), 8'd0);
    add_random(q, CRC_BYTES);
    send_field(q, LEN_W'(q.size()));
    // No room for the first segment header
    q = field_head('1, 8'd1);
    add_random(q, CRC_BYTES);
    send_field(q, LEN_W'(q.size()));
    // Empty plain segment at the earliest offset, zero media time
    q = field_head('0, 8'd1);
    add_segment(q, KIND_PLAIN, 0);
    add_random(q, CRC_BYTES);
    send_field(q, LEN_W'(q.size()));
    // Gzip segment
    q = field_head(RAW_W'({$urandom, $urandom}), 8'd2);
    add_segment(q, KIND_GZIP, 5);
    add_random(q, CRC_BYTES);
    send_field(q, LEN_W'(q.size()));
    // Skip two foreign types, then a plain segment
    q = field_head(RAW_W'({$urandom, $urandom}), 8'd3);
    add_segment(q, 8'h00, 2);
    add_segment(q, 8'hFF, 0);
    add_segment(q, KIND_PLAIN, 3);
    add_random(q, CRC_BYTES);
    send_field(q, LEN_W'(q.size()));
    // Count used up before the TTML segment
    q = field_head(RAW_W'({$urandom, $urandom}), 8'd1);
    add_segment(q, 8'h03, 2);
    add_segment(q, KIND_PLAIN, 2);
    add_random(q, CRC_BYTES);
    send_field(q, LEN_W'(q.size()));
    // Next header would run into the CRC after a skip
    q = field_head(RAW_W'({$urandom, $urandom}), 8'hFF);
    add_segment(q, 8'h80, 1);
    add_random(q, CRC_BYTES);
    send_field(q, LEN_W'(q.size()));
    // Segment length far past the field end
    q = field_head(RAW_W'({$urandom, $urandom}), 8'd1);
    add_seg_header(q, KIND_PLAIN, 16'hFFFF);
    add_random(q, 6);
    send_field(q, LEN_W'(q.size()));
    // Payload ends exactly at the CRC
    q = field_head(RAW_W'({$urandom, $urandom}), 8'd1);
    add_segment(q, KIND_GZIP, 9);
    add_random(q, CRC_BYTES);
    send_field(q, LEN_W'(q.size()));
    // Payload one byte past the CRC boundary
    q = field_head(RAW_W'({$urandom, $urandom}), 8'd1);
    add_seg_header(q, KIND_PLAIN, 16'd10);
    add_random(q, 9 + CRC_BYTES);
    send_field(q, LEN_W'(q.size()));
    // Trailing bytes after the found segment
    q = field_head(RAW_W'({$urandom, $urandom}), 8'd1);
    add_segment(q, KIND_PLAIN, 4);
    add_random(q, CRC_BYTES);
    send_field(q, LEN_W'(q.size() + 5));
  endtask

  // Extremes of the time scale, mostly against the largest media time
  task automatic test_time_scale();
    byte_q_t q;
    q = field_head('1, 8'd1);
    add_segment(q, KIND_PLAIN, 1);
    add_random(q, CRC_BYTES);
    program_time_scale('1);
    send_field(q, LEN_W'(q.size()));
    program_time_scale('0);
    send_field(q, LEN_W'(q.size()));
    program_time_scale(12'd1);
    send_field(q, LEN_W'(q.size()));
    q = field_head(RAW_W'({$urandom, $urandom}), 8'd1);
    add_segment(q, KIND_GZIP, 2);
    add_random(q, CRC_BYTES);
    send_field(q, LEN_W'(q.size()));
  endtask

  // Mostly well-formed random fields, some cut short, some overlong, some
  // pure noise, under a fresh time scale in each phase.
  task automatic test_random_fields(input int unsigned byte_goal,
                                    input int unsigned field_goal,
                                    input int unsigned phases);
    byte_q_t q;
    logic [LEN_W-1:0] flen;
    int unsigned ph;
    int unsigned start_bytes;
    int unsigned fields;
    int unsigned cut;
    for (ph = 0; ph < phases; ph++) begin
      case ($urandom_range(0, 3))
        0:       program_time_scale(12'd1);
        1:       program_time_scale('1);
        default: program_time_scale(SCALE_W'($urandom_range(1, 4095)));
      endcase
      start_bytes = bytes_sent;
      fields      = 0;
      while (bytes_sent - start_bytes < byte_goal / phases || fields < field_goal / phases) begin
        q    = build_random_field();
        flen = LEN_W'(q.size());
        case ($urandom_range(0, 19))
          0, 1: begin
            cut  = $urandom_range(1, 8);
            flen = (q.size() > cut) ? LEN_W'(q.size() - cut) : 16'd1;
          end
          2: flen = LEN_W'(q.size() + $urandom_range(1, 6));
          3: begin
            q = {};
            add_random(q, $urandom_range(1, 24));
            flen = LEN_W'(q.size());
          end
          4: flen = LEN_W'($urandom_range(0, MIN_FIELD_BYTES - 1));
          default: ;
        endcase
        send_field(q, flen);
        fields++;
      end
    end
  endtask

  // Longer fields, one with a payload offset past the first 256 bytes
  task automatic test_long_fields();
    byte_q_t q;
    q = field_head(RAW_W'({$urandom, $urandom}), 8'd2);
    add_segment(q, 8'h42, 250);
    add_segment(q, KIND_PLAIN, 6);
    add_random(q, CRC_BYTES);
    send_field(q, LEN_W'(q.size()));
    q = field_head('1, 8'd1);
    add_segment(q, KIND_GZIP, 20);
    add_random(q, CRC_BYTES);
    send_field(q, LEN_W'(q.size()));
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run
    byte_bus.valid        <= 1'b0;
    byte_bus.data_byte    <= '0;
    byte_bus.field_length <= '0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.time_scale    <= '0;
    rst_ni                <= 1'b0;
    loc_scale = TIME_SCALE_RESET;
    clear_field();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_fields();
    test_segment_walk();
    test_time_scale();
    test_random_fields(RANDOM_BYTES, RANDOM_FIELDS, 4);

    // Closing part: no gaps and no stalls
    quiet_tail = 1'b1;
    test_long_fields();
    test_random_fields(30, 1, 1);

    // Drain every outstanding result, then watch for strays
    byte_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("missing results", '0, pending_results.size());

    $display("Covered %0d fields in %0d bytes under %0d time_scale writes; %0d results compared.",
             fields_sent, bytes_sent, scale_writes, results_seen);
    $display("Status spread: plain %0d, gzip %0d, short %0d, no segments %0d, cut header %0d, %s",
             status_tally[ST_PLAIN], status_tally[ST_GZIP], status_tally[ST_SHORT],
             status_tally[ST_NOSEG], status_tally[ST_TRUNC_HDR],
             $sformatf("cut segment %0d, none %0d",
                       status_tally[ST_TRUNC_SEG], status_tally[ST_NONE]));
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> ttml_pes_segment_locator_core.f
sv/tpsl_pkg.sv
sv/tpsl_if.sv
sv/tpsl_in_reg.sv
sv/tpsl_parser.sv
sv/tpsl_out_reg.sv
sv/ttml_pes_segment_locator_core.sv
tb/tb.sv
